// File: hw/rtl/lslm_pkg.sv
// Shared types and constants for the luma stability lock mask block.
package lslm_pkg;

	// Rec.709 luma coefficients, Q0.16, summing to 1.0
	localparam logic [15:0] COEF_R = 16'd13933;
	localparam logic [15:0] COEF_G = 16'd46871;
	localparam logic [15:0] COEF_B = 16'd4732;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;

	// Register indexes
	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// One line-buffer entry: row above, center row, center weights
	typedef struct packed {
		logic [15:0] above;
		logic [15:0] center;
		logic [16:0] wt;
	} lslm_row_t;

	// Divider handshake
	typedef struct packed {
		logic start;
		logic [17:0] dev;
		logic [17:0] den;
	} lslm_div_req_t;

	typedef struct packed {
		logic done;
		logic [16:0] quo;
	} lslm_div_rsp_t;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_LUMA = 7'b0000100,
		S_WIN  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_MUL  = 7'b0100000,
		S_HOLD = 7'b1000000
	} lslm_state_t;

endpackage

// File: hw/rtl/lslm_line_mem.sv
// Line-buffer memory: one write port, one read port, registered read data.
module lslm_line_mem #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/lslm_lock_div.sv
// Iterative restoring divider: quo = (dev << 16) / den, one quotient bit per cycle.
module lslm_lock_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lslm_pkg::lslm_div_req_t req,
	output lslm_pkg::lslm_div_rsp_t rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [17:0] rem_q;
	logic [17:0] den_q;
	logic        bin_q;
	logic [16:0] quo_q;
	logic        done_q;
	logic [18:0] trial;
	logic        take;

	// dev <= den always holds, so the quotient fits 17 bits
	assign trial = {rem_q, bin_q};
	assign take = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dev[17:1]};
			bin_q <= req.dev[0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? 18'(trial - {1'b0, den_q}) : trial[17:0];
			bin_q <= 1'b0;
			quo_q <= {quo_q[15:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

// File: hw/rtl/luma_stability_lock_mask_top.sv
// Top level: luma, line buffers, five-point window and lock computation.
//
// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_stall  | kind, red, green, blue, disocclusion_weight
// output   | out       | out_valid/out_stall| lock_value, center_luma, frame_last
// config   | in        | cfg_we             | cfg_index, cfg_data
//
// An item with no result passes LUMA and WIN; one whose five lumas are flat passes
// LUMA, WIN, MUL and HOLD; any other also waits in DIV for the 17-step serial divider.
// The line buffers are one memory read and written once per item.
// After reset a clearing pass zeroes all MAX_WIDTH line-buffer entries;
// no item is accepted meanwhile. A stalled output holds one result while the
// next item is taken; the block then waits before loading its own result.
module luma_stability_lock_mask_top #(
	parameter int MAX_WIDTH = 4096,
	parameter int COLOR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic [16:0] disocclusion_weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] lock_value,
	output logic [15:0] center_luma,
	output logic        frame_last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = 14;
	localparam int EW = $bits(lslm_pkg::lslm_row_t);
	localparam logic [15:0] CMASK =
		(COLOR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COLOR_BITS) - 32'd1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

	lslm_pkg::lslm_state_t state_q;

	logic [12:0] width_q, height_q;
	logic [WW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] clr_q;

	logic [31:0] pr_s1, pg_s1, pb_s1;
	logic        pix_s1;
	logic [16:0] wt_s1;
	logic [15:0] luma_s2;

	logic [15:0] win0_q, win1_q, win2_q, win3_q;
	logic [16:0] whold_q;

	lslm_pkg::lslm_row_t rd_row, wr_row;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;

	lslm_pkg::lslm_div_req_t div_req;
	lslm_pkg::lslm_div_rsp_t div_rsp;

	logic [15:0] ce_s3;
	logic [16:0] wt_s3;
	logic        last_s3;
	logic [16:0] lockv_q;
	logic        out_valid_q;
	logic [16:0] lock_out_q;
	logic [15:0] luma_out_q;
	logic        last_out_q;

	logic        in_acc;
	logic [32:0] luma_sum;
	logic        emit, last_w;
	logic [WW-1:0] cx;
	logic [RW-1:0] cy;
	logic [15:0] up, dn, lf, rt, ce, mx, mn;
	logic [17:0] ring, four, dev;
	logic [15:0] rng;
	logic [16:0] stab;
	logic [33:0] prod;
	logic        out_free;

	// Effective frame size
	always_comb begin
		if (width_q == 13'd0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == 13'd0) ? RW'(1) : RW'(height_q);
	end

	assign in_stall = (state_q != lslm_pkg::S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Window position of the emitted center
	always_comb begin
		emit = (row_q >= RW'(2)) || (row_q == RW'(1) && col_q != '0);
		cx = (col_q == '0) ? WW'(w_eff - WW'(1)) : WW'(WW'(col_q) - WW'(1));
		cy = (col_q == '0) ? RW'(row_q - RW'(2)) : RW'(row_q - RW'(1));
		last_w = emit && (col_q == '0) && (row_q == RW'(h_eff + RW'(1)));
		ce = win1_q;
		up = (cy == '0) ? ce : win3_q;
		dn = (cy >= RW'(h_eff - RW'(1))) ? ce : win0_q;
		lf = (cx == '0) ? ce : win2_q;
		rt = (cx == WW'(w_eff - WW'(1))) ? ce : rd_row.center;
		mx = ce;
		mn = ce;
		if (up > mx) mx = up;
		if (lf > mx) mx = lf;
		if (rt > mx) mx = rt;
		if (dn > mx) mx = dn;
		if (up < mn) mn = up;
		if (lf < mn) mn = lf;
		if (rt < mn) mn = rt;
		if (dn < mn) mn = dn;
		rng = mx - mn;
		ring = 18'(up) + 18'(lf) + 18'(rt) + 18'(dn);
		four = {ce, 2'b00};
		dev = (ring >= four) ? 18'(ring - four) : 18'(four - ring);
	end

	assign luma_sum = 33'(pr_s1) + 33'(pg_s1) + 33'(pb_s1) + 33'd32768;
	assign stab = (div_rsp.quo > lslm_pkg::ONE_Q16) ? 17'd0 :
		17'(lslm_pkg::ONE_Q16 - div_rsp.quo);
	assign prod = 34'(lockv_q) * 34'(wt_s3);

	assign div_req.start = (state_q == lslm_pkg::S_WIN) && emit && (rng != '0);
	assign div_req.dev = dev;
	assign div_req.den = {rng, 2'b00};

	// Line buffer port
	always_comb begin
		wr_row.above = rd_row.center;
		wr_row.center = luma_s2;
		wr_row.wt = whold_q;
		mem_we = (state_q == lslm_pkg::S_WIN);
		mem_waddr = col_q;
		if (state_q == lslm_pkg::S_CLR) begin
			wr_row = '0;
			mem_we = 1'b1;
			mem_waddr = clr_q;
		end
	end

	lslm_line_mem #(
		.WIDTH(EW),
		.DEPTH(MAX_WIDTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(wr_row),
		.raddr(col_q),
		.rdata(rd_row)
	);

	lslm_lock_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Control: sequencer, counters, config, output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lslm_pkg::S_CLR;
			width_q <= 13'd1920;
			height_q <= 13'd1080;
			col_q <= '0;
			row_q <= '0;
			clr_q <= '0;
			win0_q <= '0;
			win1_q <= '0;
			win2_q <= '0;
			win3_q <= '0;
			whold_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Output slot: filled from HOLD when free, cleared once taken
			if (state_q == lslm_pkg::S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lslm_pkg::S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= lslm_pkg::S_IDLE;
					end
				end
				lslm_pkg::S_IDLE: begin
					if (in_acc) begin
						state_q <= lslm_pkg::S_LUMA;
					end
				end
				lslm_pkg::S_LUMA: begin
					state_q <= lslm_pkg::S_WIN;
				end
				lslm_pkg::S_WIN: begin
					win2_q <= win1_q;
					win1_q <= rd_row.center;
					win3_q <= rd_row.above;
					win0_q <= luma_s2;
					whold_q <= wt_s1;
					if (last_w) begin
						col_q <= '0;
						row_q <= '0;
					end else if (WW'(col_q) + WW'(1) >= w_eff) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
					if (!emit) begin
						state_q <= lslm_pkg::S_IDLE;
					end else if (rng == '0) begin
						state_q <= lslm_pkg::S_MUL;
					end else begin
						state_q <= lslm_pkg::S_DIV;
					end
				end
				lslm_pkg::S_DIV: begin
					if (div_rsp.done) begin
						state_q <= lslm_pkg::S_MUL;
					end
				end
				lslm_pkg::S_MUL: begin
					state_q <= lslm_pkg::S_HOLD;
				end
				lslm_pkg::S_HOLD: begin
					if (out_free) begin
						state_q <= lslm_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= lslm_pkg::S_IDLE;
				end
			endcase
			if (cfg_we) begin
				if (cfg_index == lslm_pkg::CFG_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= !kind && (row_q < h_eff);
			pr_s1 <= 32'(red & CMASK) * 32'(lslm_pkg::COEF_R);
			pg_s1 <= 32'(green & CMASK) * 32'(lslm_pkg::COEF_G);
			pb_s1 <= 32'(blue & CMASK) * 32'(lslm_pkg::COEF_B);
			wt_s1 <= (disocclusion_weight > lslm_pkg::ONE_Q16) ?
				lslm_pkg::ONE_Q16 : disocclusion_weight;
		end
		if (state_q == lslm_pkg::S_LUMA) begin
			luma_s2 <= pix_s1 ? luma_sum[31:16] : 16'd0;
			if (!pix_s1) begin
				wt_s1 <= '0;
			end
		end
		if (state_q == lslm_pkg::S_WIN) begin
			ce_s3 <= ce;
			wt_s3 <= rd_row.wt;
			last_s3 <= last_w;
			lockv_q <= lslm_pkg::ONE_Q16;
		end
		if (state_q == lslm_pkg::S_DIV && div_rsp.done) begin
			lockv_q <= (stab > lslm_pkg::HALF_Q16) ? stab : 17'd0;
		end
		// Result enters the output slot only once the slot is free
		if (state_q == lslm_pkg::S_HOLD && out_free) begin
			lock_out_q <= prod[32:16];
			luma_out_q <= ce_s3;
			last_out_q <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign lock_value = lock_out_q;
	assign center_luma = luma_out_q;
	assign frame_last = last_out_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lslm_pkg::S_CLR) |-> in_stall)
		else $error("item accepted during line buffer clear");

	a_lock_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lock_out_q <= lslm_pkg::ONE_Q16))
		else $error("lock value above one");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lslm_pkg::S_WIN && last_w && !cfg_we) |=>
			(col_q == '0 && row_q == '0))
		else $error("frame counters not restarted after last result");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == lslm_pkg::S_DIV))
		else $error("divider finished outside divide state");
`endif

endmodule
